// ===== hdl/bptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

    // Configuration register indexes
    typedef logic [7:0] cfg_idx_t;
    localparam cfg_idx_t CFG_IDX_TEMP    = 8'd0;
    localparam cfg_idx_t CFG_IDX_PRESS_A = 8'd1;
    localparam cfg_idx_t CFG_IDX_PRESS_B = 8'd2;
    localparam cfg_idx_t CFG_IDX_PRESS_C = 8'd3;

    // Offset removed from P1 and P2
    localparam logic signed [16:0] CAL_HALF_OFFSET = 17'sd16384;

    // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT for any x below 2^32
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    // Full scale and one unit of the pressure output, in Pa with 16 fraction bits, taken >> 16
    localparam logic [25:0] PRESS_FULL_SCALE = 26'd655360;
    localparam logic [25:0] PRESS_ONE_UNIT   = 26'd10;

    // Pipeline depth, input register to output register
    localparam int NSTG = 12;

endpackage

`default_nettype wire

// ===== hdl/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: an accepted input word passes through the stage registers to its result word on m_tdata.
// Throughput: one word per cycle while m_tready is high; every stage has its own valid bit
// and a stage takes a new word when it is empty or its word moves on, so bubbles collapse.
// Reset: aresetn (synchronous, active low) empties the pipeline and clears the
// four calibration registers to zero.
module baro_temp_pressure_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // calibration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire bptc_pkg::cfg_idx_t cfg_index,
    input  wire logic [47:0] cfg_data,
    // raw readings
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
    // compensated results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] temperature_tenths, [31:16] pressure_tenth_hpa
    output logic             m_tuser    // [0] saturated
);
    import bptc_pkg::*;

    // ------------------------------------------------------------------
    // Calibration registers, always ready; user must write only while idle; not enforced here.
    // ------------------------------------------------------------------
    logic [39:0] cal_t_reg;
    logic [47:0] cal_pa_reg;
    logic [47:0] cal_pb_reg;
    logic [31:0] cal_pc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t_reg  <= '0;
            cal_pa_reg <= '0;
            cal_pb_reg <= '0;
            cal_pc_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_TEMP:    cal_t_reg  <= cfg_data[39:0];
                CFG_IDX_PRESS_A: cal_pa_reg <= cfg_data;
                CFG_IDX_PRESS_B: cal_pb_reg <= cfg_data;
                CFG_IDX_PRESS_C: cal_pc_reg <= cfg_data[31:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Coefficient fields
    logic        [15:0] t1;
    logic        [15:0] t2c;
    logic signed [7:0]  t3c;
    logic signed [16:0] p1m;
    logic signed [16:0] p2m;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;

    assign t1  = cal_t_reg[15:0];
    assign t2c = cal_t_reg[31:16];
    assign t3c = $signed(cal_t_reg[39:32]);
    assign p1m = $signed({cal_pa_reg[15], cal_pa_reg[15:0]}) - CAL_HALF_OFFSET;
    assign p2m = $signed({cal_pa_reg[31], cal_pa_reg[31:16]}) - CAL_HALF_OFFSET;
    assign p3  = $signed(cal_pa_reg[39:32]);
    assign p4  = $signed(cal_pa_reg[47:40]);
    assign p5  = cal_pb_reg[15:0];
    assign p6  = cal_pb_reg[31:16];
    assign p7  = $signed(cal_pb_reg[39:32]);
    assign p8  = $signed(cal_pb_reg[47:40]);
    assign p9  = $signed(cal_pc_reg[15:0]);
    assign p10 = $signed(cal_pc_reg[23:16]);
    assign p11 = $signed(cal_pc_reg[31:24]);

    // ------------------------------------------------------------------
    // Pipeline control: stage k (index k-1) loads when empty or draining.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: temperature offset d = raw_t - T1*256, raw pressure squared
    // ------------------------------------------------------------------
    logic signed [24:0] d1_reg,    d1_next;
    logic        [47:0] rpsq1_reg, rpsq1_next;
    logic        [23:0] rp1_reg;

    assign d1_next    = $signed({1'b0, s_tdata[23:0]}) - $signed({1'b0, t1, 8'b0});
    assign rpsq1_next = s_tdata[47:24] * s_tdata[47:24];

    // Stage 2: d*T2 and d*d; q = raw_p^2 >> 16
    logic signed [41:0] dt2_2_reg, dt2_2_next;
    logic signed [49:0] dd_full;
    logic        [47:0] dd2_reg,   dd2_next;
    logic        [31:0] q2_reg,    q2_next;
    logic        [23:0] rp2_reg;

    assign dt2_2_next = d1_reg * $signed({1'b0, t2c});
    assign dd_full    = d1_reg * d1_reg;
    assign dd2_next   = dd_full[47:0];
    assign q2_next    = rpsq1_reg[47:16];

    // Stage 3: t in Q12.24, q*raw_p
    logic signed [56:0] ddt3;
    logic signed [59:0] tnum;
    logic signed [35:0] t3_reg,  t3_next;
    logic        [55:0] qr3_reg, qr3_next;
    logic        [31:0] q3_reg;
    logic        [23:0] rp3_reg;

    assign ddt3     = $signed({1'b0, dd2_reg}) * t3c;
    assign tnum     = (60'(dt2_2_reg) <<< 18) + 60'(ddt3);
    assign t3_next  = tnum[59:24];
    assign qr3_next = q2_reg * rp2_reg;

    // Stage 4: clamp t to 32 bits, tenths magnitude, P11 term product
    logic signed [31:0] tp4_reg,  tp4_next;
    logic        [35:0] tabs;
    logic        [39:0] ten10;
    logic        [15:0] tmag4_reg, tmag4_next;
    logic               tneg4_reg, tneg4_next;
    logic signed [56:0] o4m4_reg, o4m4_next;
    logic        [31:0] q4_reg;
    logic        [23:0] rp4_reg;

    always_comb begin
        if (t3_reg[35:31] == 5'b00000 || t3_reg[35:31] == 5'b11111) begin
            tp4_next = t3_reg[31:0];
        end else if (t3_reg[35]) begin
            tp4_next = 32'sh8000_0000;
        end else begin
            tp4_next = 32'sh7FFF_FFFF;
        end
    end

    assign tabs       = t3_reg[35] ? 36'(-t3_reg) : 36'(t3_reg);
    assign ten10      = {tabs, 3'b000} + {3'b000, tabs, 1'b0};
    assign tmag4_next = ten10[39:24];
    assign tneg4_next = t3_reg[35];
    assign o4m4_next  = $signed({1'b0, qr3_reg[55:8]}) * p11;

    // Stage 5: products with the clamped temperature, temperature saturation
    logic signed [63:0] sq5_reg,   sq5_next;
    logic signed [48:0] p6t5_reg,  p6t5_next;
    logic signed [48:0] p2t5_reg,  p2t5_next;
    logic signed [39:0] p10t5_reg, p10t5_next;
    logic signed [31:0] tp5_reg;
    logic signed [31:0] o4_5_reg,  o4_5_next;
    logic        [15:0] ten5_reg,  ten5_next;
    logic               satt5_reg, satt5_next;
    logic        [31:0] q5_reg;
    logic        [23:0] rp5_reg;

    assign sq5_next   = tp4_reg * tp4_reg;
    assign p6t5_next  = $signed({1'b0, p6}) * tp4_reg;
    assign p2t5_next  = p2m * tp4_reg;
    assign p10t5_next = p10 * tp4_reg;
    assign o4_5_next  = o4m4_reg[56:25];

    always_comb begin
        satt5_next = 1'b0;
        if (!tneg4_reg) begin
            if (tmag4_reg > 16'd32767) begin
                ten5_next  = 16'h7FFF;
                satt5_next = 1'b1;
            end else begin
                ten5_next = tmag4_reg;
            end
        end else begin
            if (tmag4_reg > 16'd32768) begin
                ten5_next  = 16'h8000;
                satt5_next = 1'b1;
            end else begin
                ten5_next = 16'(-tmag4_reg);
            end
        end
    end

    // Stage 6: t2 terms, cube product, quadratic pressure coefficient v
    logic        [38:0] tsq6;
    logic signed [63:0] cu6_reg,  cu6_next;
    logic signed [47:0] p7t6_reg, p7t6_next;
    logic signed [47:0] p3t6_reg, p3t6_next;
    logic signed [40:0] vsum;
    logic signed [24:0] v6_reg,   v6_next;
    logic signed [48:0] p6t6_reg;
    logic signed [48:0] p2t6_reg;
    logic signed [31:0] o4_6_reg;
    logic        [15:0] ten6_reg;
    logic               satt6_reg;
    logic        [31:0] q6_reg;
    logic        [23:0] rp6_reg;

    assign tsq6      = sq5_reg[62:24];
    assign cu6_next  = $signed({1'b0, sq5_reg[62:32]}) * tp5_reg;
    assign p7t6_next = p7 * $signed({1'b0, tsq6});
    assign p3t6_next = p3 * $signed({1'b0, tsq6});
    assign vsum      = (41'(p9) <<< 24) + 41'(p10t5_reg);
    assign v6_next   = vsum[40:16];

    // Stage 7: t3 terms and q*v
    logic signed [46:0] tcu7;
    logic signed [54:0] p8t7_reg, p8t7_next;
    logic signed [54:0] p4t7_reg, p4t7_next;
    logic signed [57:0] qv7_reg,  qv7_next;
    logic signed [48:0] p6t7_reg;
    logic signed [48:0] p2t7_reg;
    logic signed [47:0] p7t7_reg;
    logic signed [47:0] p3t7_reg;
    logic signed [31:0] o4_7_reg;
    logic        [15:0] ten7_reg;
    logic               satt7_reg;
    logic        [23:0] rp7_reg;

    assign tcu7      = cu6_reg[62:16];
    assign p8t7_next = p8 * tcu7;
    assign p4t7_next = p4 * tcu7;
    assign qv7_next  = $signed({1'b0, q6_reg}) * v6_reg;

    // Stage 8: offset o1, sensitivity s, o3
    logic signed [60:0] o1sum;
    logic signed [60:0] ssum;
    logic signed [37:0] o1_8_reg, o1_8_next;
    logic signed [31:0] s8_reg,   s8_next;
    logic signed [33:0] o3_8_reg, o3_8_next;
    logic signed [31:0] o4_8_reg;
    logic        [15:0] ten8_reg;
    logic               satt8_reg;
    logic        [23:0] rp8_reg;

    assign o1sum = $signed({3'b000, p5, 42'b0}) + (61'(p6t7_reg) <<< 9)
                 + (61'(p7t7_reg) <<< 7) + 61'(p8t7_reg);
    assign ssum  = (61'(p1m) <<< 41) + (61'(p2t7_reg) <<< 8)
                 + (61'(p3t7_reg) <<< 5) + 61'(p4t7_reg);
    assign o1_8_next = o1sum[60:23];
    assign s8_next   = ssum[60:29];
    assign o3_8_next = qv7_reg[57:24];

    // Stage 9: raw_p * s
    logic signed [56:0] o2m9_reg, o2m9_next;
    logic signed [37:0] o1_9_reg;
    logic signed [33:0] o3_9_reg;
    logic signed [31:0] o4_9_reg;
    logic        [15:0] ten9_reg;
    logic               satt9_reg;

    assign o2m9_next = $signed({1'b0, rp8_reg}) * s8_reg;

    // Stage 10: pressure sum in Pa, 16 fraction bits
    logic signed [41:0] p10_reg, p10_next;
    logic        [15:0] ten10_reg;
    logic               satt10_reg;

    assign p10_next = 42'(o1_9_reg) + 42'($signed(o2m9_reg[56:16])) + 42'(o3_9_reg)
                    + 42'(o4_9_reg);

    // Stage 11: magnitude in whole Pa, range flags
    logic        [41:0] pmag;
    logic        [25:0] px;
    logic        [19:0] xc11_reg,  xc11_next;
    logic               big11_reg, big11_next;
    logic               neg11_reg, neg11_next;
    logic               nsat11_reg, nsat11_next;
    logic        [15:0] ten11_reg;
    logic               satt11_reg;

    assign pmag        = p10_reg[41] ? 42'(-p10_reg) : 42'(p10_reg);
    assign px          = pmag[41:16];
    assign big11_next  = px >= PRESS_FULL_SCALE;
    assign xc11_next   = big11_next ? 20'd0 : px[19:0];
    assign neg11_next  = p10_reg[41];
    assign nsat11_next = px >= PRESS_ONE_UNIT;

    // Stage 12: divide by ten, saturate, output register
    logic [51:0] quo_full;
    logic [15:0] pres_next;
    logic        sat_next;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign quo_full = xc11_reg * RECIP10;

    always_comb begin
        if (neg11_reg) begin
            pres_next = 16'd0;
            sat_next  = satt11_reg || nsat11_reg;
        end else if (big11_reg) begin
            pres_next = 16'hFFFF;
            sat_next  = 1'b1;
        end else begin
            pres_next = quo_full[RECIP10_SHIFT +: 16];
            sat_next  = satt11_reg;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // ------------------------------------------------------------------
    // Payload registers: advance with the stage enable, no reset.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_reg    <= d1_next;
            rpsq1_reg <= rpsq1_next;
            rp1_reg   <= s_tdata[47:24];
        end
        if (en[1]) begin
            dt2_2_reg <= dt2_2_next;
            dd2_reg   <= dd2_next;
            q2_reg    <= q2_next;
            rp2_reg   <= rp1_reg;
        end
        if (en[2]) begin
            t3_reg  <= t3_next;
            qr3_reg <= qr3_next;
            q3_reg  <= q2_reg;
            rp3_reg <= rp2_reg;
        end
        if (en[3]) begin
            tp4_reg   <= tp4_next;
            tmag4_reg <= tmag4_next;
            tneg4_reg <= tneg4_next;
            o4m4_reg  <= o4m4_next;
            q4_reg    <= q3_reg;
            rp4_reg   <= rp3_reg;
        end
        if (en[4]) begin
            sq5_reg   <= sq5_next;
            p6t5_reg  <= p6t5_next;
            p2t5_reg  <= p2t5_next;
            p10t5_reg <= p10t5_next;
            tp5_reg   <= tp4_reg;
            o4_5_reg  <= o4_5_next;
            ten5_reg  <= ten5_next;
            satt5_reg <= satt5_next;
            q5_reg    <= q4_reg;
            rp5_reg   <= rp4_reg;
        end
        if (en[5]) begin
            cu6_reg   <= cu6_next;
            p7t6_reg  <= p7t6_next;
            p3t6_reg  <= p3t6_next;
            v6_reg    <= v6_next;
            p6t6_reg  <= p6t5_reg;
            p2t6_reg  <= p2t5_reg;
            o4_6_reg  <= o4_5_reg;
            ten6_reg  <= ten5_reg;
            satt6_reg <= satt5_reg;
            q6_reg    <= q5_reg;
            rp6_reg   <= rp5_reg;
        end
        if (en[6]) begin
            p8t7_reg  <= p8t7_next;
            p4t7_reg  <= p4t7_next;
            qv7_reg   <= qv7_next;
            p6t7_reg  <= p6t6_reg;
            p2t7_reg  <= p2t6_reg;
            p7t7_reg  <= p7t6_reg;
            p3t7_reg  <= p3t6_reg;
            o4_7_reg  <= o4_6_reg;
            ten7_reg  <= ten6_reg;
            satt7_reg <= satt6_reg;
            rp7_reg   <= rp6_reg;
        end
        if (en[7]) begin
            o1_8_reg  <= o1_8_next;
            s8_reg    <= s8_next;
            o3_8_reg  <= o3_8_next;
            o4_8_reg  <= o4_7_reg;
            ten8_reg  <= ten7_reg;
            satt8_reg <= satt7_reg;
            rp8_reg   <= rp7_reg;
        end
        if (en[8]) begin
            o2m9_reg  <= o2m9_next;
            o1_9_reg  <= o1_8_reg;
            o3_9_reg  <= o3_8_reg;
            o4_9_reg  <= o4_8_reg;
            ten9_reg  <= ten8_reg;
            satt9_reg <= satt8_reg;
        end
        if (en[9]) begin
            p10_reg    <= p10_next;
            ten10_reg  <= ten9_reg;
            satt10_reg <= satt9_reg;
        end
        if (en[10]) begin
            xc11_reg   <= xc11_next;
            big11_reg  <= big11_next;
            neg11_reg  <= neg11_next;
            nsat11_reg <= nsat11_next;
            ten11_reg  <= ten10_reg;
            satt11_reg <= satt10_reg;
        end
        if (en[11]) begin
            m_tdata_reg <= {pres_next, ten11_reg};
            m_tuser_reg <= sat_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted word shows up in the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter stage 1");

    // A negative pressure sum always leaves as zero pressure.
    a_neg_press_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NSTG-2] && en[NSTG-1] && neg11_reg |=> m_tdata[31:16] == 16'd0)
        else $error("negative pressure not forced to zero");

    // An out-of-range pressure magnitude always flags saturation.
    a_big_press_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NSTG-2] && en[NSTG-1] && big11_reg |=> m_tuser)
        else $error("pressure clamp without saturation flag");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
